// ===== rtl/utp_pkg.sv =====
package utp_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BOUNDARY = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  // slots of one command, emitted lowest first
  localparam int NSLOTS = 7;
  localparam logic [2:0] SLOT_PRE   = 3'd0;
  localparam logic [2:0] SLOT_BYTE0 = 3'd1;
  localparam logic [2:0] SLOT_BYTE1 = 3'd2;
  localparam logic [2:0] SLOT_BYTE2 = 3'd3;
  localparam logic [2:0] SLOT_BYTE3 = 3'd4;
  localparam logic [2:0] SLOT_POST  = 3'd5;
  localparam logic [2:0] SLOT_END   = 3'd6;

  // work for the back end: which slots fire and the encoded bytes
  typedef struct packed {
    logic [NSLOTS-1:0] mask;
    logic [3:0][7:0]   bytes;
  } cmd_t;

endpackage

// ===== rtl/utp_if.sv =====
interface utp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

// ===== rtl/utp_front.sv =====
module utp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_data,
  utp_in_if.sink        text_in,
  input  logic          q_full,
  output logic          push,
  output utp_pkg::cmd_t cmd
);
  import utp_pkg::*;

  function automatic logic is_space(input logic [20:0] cp);
    return cp inside {21'h20, 21'h09, 21'h0A, 21'h0D, 21'hA0, 21'h1680,
                      [21'h2000:21'h200A], 21'h202F, 21'h205F, 21'h3000};
  endfunction

  function automatic logic is_ctrl(input logic [20:0] cp);
    if (cp inside {21'h09, 21'h0A, 21'h0D}) return 1'b0;
    return cp inside {[21'h00:21'h1F], 21'h7F, [21'h80:21'h9F]};
  endfunction

  function automatic logic is_punct(input logic [20:0] cp);
    return cp inside {[21'd33:21'd47], [21'd58:21'd64], [21'd91:21'd96],
                      [21'd123:21'd126], [21'h2000:21'h206F], [21'h3000:21'h303F],
                      [21'hFF00:21'hFF0F], [21'hFF1A:21'hFF20],
                      [21'hFF3B:21'hFF40], [21'hFF5B:21'hFF65]};
  endfunction

  function automatic logic is_cjk(input logic [20:0] cp);
    return cp inside {[21'h4E00:21'h9FFF], [21'h3400:21'h4DBF],
                      [21'h20000:21'h2A6DF], [21'h2A700:21'h2B73F],
                      [21'h2B740:21'h2B81F], [21'h2B820:21'h2CEAF],
                      [21'hF900:21'hFAFF], [21'h2F800:21'h2FA1F]};
  endfunction

  function automatic logic [20:0] fold_case(input logic [20:0] cp);
    if (cp inside {[21'h41:21'h5A], [21'hC0:21'hD6], [21'hD8:21'hDE]})
      return cp + 21'd32;
    return cp;
  endfunction

  logic        lower_case;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [20:0] partial, partial_next;
  logic        word_open, word_open_next;

  logic        accept;
  logic        cp_hit;
  logic [20:0] cp, cp_out, cont;
  logic [1:0]  pend_dec;
  logic        pre, emit, post, fin;
  logic [3:0]  nmask;
  logic [3:0][7:0] enc;

  assign text_in.ready = !q_full;
  assign accept = text_in.valid && text_in.ready;

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_next       = partial;
    word_open_next     = word_open;
    cp_hit   = 1'b0;
    cp       = '0;
    cont     = {partial[14:0], text_in.in_byte[5:0]};
    pend_dec = bytes_pending - 2'd1;

    // utf-8 decode
    if (bytes_pending != 2'd0) begin
      if (text_in.in_byte[7:6] == 2'b10) begin
        bytes_pending_next = pend_dec;
        if (pend_dec == 2'd0) begin
          cp_hit       = 1'b1;
          cp           = cont;
          partial_next = '0;
        end else begin
          partial_next = cont;
        end
      end else begin
        bytes_pending_next = 2'd0;
        partial_next       = '0;
      end
    end else if (!text_in.in_byte[7]) begin
      cp_hit = 1'b1;
      cp     = {13'd0, text_in.in_byte};
    end else if (text_in.in_byte[7:5] == 3'b110) begin
      bytes_pending_next = 2'd1;
      partial_next       = {16'd0, text_in.in_byte[4:0]};
    end else if (text_in.in_byte[7:4] == 4'b1110) begin
      bytes_pending_next = 2'd2;
      partial_next       = {17'd0, text_in.in_byte[3:0]};
    end else if (text_in.in_byte[7:3] == 5'b11110) begin
      bytes_pending_next = 2'd3;
      partial_next       = {18'd0, text_in.in_byte[2:0]};
    end

    // classify
    pre    = 1'b0;
    emit   = 1'b0;
    post   = 1'b0;
    cp_out = cp;
    if (cp_hit && cp != 21'd0 && cp != 21'hFFFD && !is_ctrl(cp)) begin
      if (is_space(cp)) begin
        pre            = word_open;
        word_open_next = 1'b0;
      end else if (!(lower_case && cp >= 21'h0300 && cp <= 21'h036F)) begin
        cp_out = lower_case ? fold_case(cp) : cp;
        emit   = 1'b1;
        if (is_cjk(cp_out) || is_punct(cp_out)) begin
          pre            = word_open;
          post           = 1'b1;
          word_open_next = 1'b0;
        end else begin
          word_open_next = 1'b1;
        end
      end
    end

    // end of text closes any open word
    fin = 1'b0;
    if (text_in.end_of_text) begin
      bytes_pending_next = 2'd0;
      partial_next       = '0;
      post               = post | word_open_next;
      fin                = 1'b1;
      word_open_next     = 1'b0;
    end

    // re-encode
    enc = '0;
    if (cp_out < 21'h80) begin
      nmask  = 4'b0001;
      enc[0] = cp_out[7:0];
    end else if (cp_out < 21'h800) begin
      nmask  = 4'b0011;
      enc[0] = {3'b110, cp_out[10:6]};
      enc[1] = {2'b10, cp_out[5:0]};
    end else if (cp_out < 21'h10000) begin
      nmask  = 4'b0111;
      enc[0] = {4'b1110, cp_out[15:12]};
      enc[1] = {2'b10, cp_out[11:6]};
      enc[2] = {2'b10, cp_out[5:0]};
    end else begin
      nmask  = 4'b1111;
      enc[0] = {5'b11110, cp_out[20:18]};
      enc[1] = {2'b10, cp_out[17:12]};
      enc[2] = {2'b10, cp_out[11:6]};
      enc[3] = {2'b10, cp_out[5:0]};
    end

    cmd.mask  = {fin, post, (emit ? nmask : 4'b0000), pre};
    cmd.bytes = enc;
  end

  assign push = accept && (cmd.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_case    <= 1'b1;
      bytes_pending <= 2'd0;
      partial       <= '0;
      word_open     <= 1'b0;
    end else begin
      if (cfg_we) lower_case <= cfg_data;
      if (accept) begin
        bytes_pending <= bytes_pending_next;
        partial       <= partial_next;
        word_open     <= word_open_next;
      end
    end
  end

endmodule

// ===== rtl/utp_queue.sv =====
module utp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output utp_pkg::cmd_t head,
  output logic          valid
);
  import utp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/utp_back.sv =====
module utp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  utp_pkg::cmd_t head,
  output logic          q_pop,
  utp_out_if.source     tok_out
);
  import utp_pkg::*;

  cmd_t              cur;
  cmd_t              eff;
  logic              have_cur, eff_valid, adv, fire;
  logic [2:0]        idx;
  logic [NSLOTS-1:0] rem;
  logic [1:0]        kind_next;
  logic [7:0]        byte_next;

  assign have_cur  = (cur.mask != '0);
  assign eff       = have_cur ? cur : head;
  assign eff_valid = have_cur || q_valid;
  assign adv       = !tok_out.valid || tok_out.ready;
  assign fire      = adv && eff_valid;
  assign q_pop     = fire && !have_cur;

  always_comb begin
    idx = SLOT_END;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (eff.mask[i]) idx = 3'(i);
    end
    rem = eff.mask & ~(NSLOTS'(1) << idx);

    kind_next = KIND_BYTE;
    byte_next = 8'd0;
    case (idx)
      SLOT_PRE, SLOT_POST: kind_next = KIND_BOUNDARY;
      SLOT_END:            kind_next = KIND_END;
      SLOT_BYTE0:          byte_next = eff.bytes[0];
      SLOT_BYTE1:          byte_next = eff.bytes[1];
      SLOT_BYTE2:          byte_next = eff.bytes[2];
      SLOT_BYTE3:          byte_next = eff.bytes[3];
      default:             kind_next = KIND_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask      <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (fire) begin
        cur.mask      <= rem;
        cur.bytes     <= eff.bytes;
        tok_out.valid <= 1'b1;
      end else if (tok_out.ready) begin
        tok_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tok_out.kind        <= kind_next;
      tok_out.out_byte    <= byte_next;
      tok_out.last_of_run <= (rem == '0);
    end
  end

endmodule

// ===== rtl/utf8_text_pretokenizer.sv =====
// channel   dir  beat payload                         handshake
// text_in   in   in_byte[7:0], end_of_text            valid/ready
// tok_out   out  kind[1:0], out_byte[7:0], last_of_run valid/ready
// cfg       in   cfg_data (lower_case)                cfg_we, no wait
//
// a byte is accepted every cycle while the command queue has room
// each byte turns into 0 to 7 results; while tok_out is not stalled, the back end
// sends one result per cycle from its output register; that single output
// register sets the rate
// rst is synchronous: lower_case returns to 1, decode state and queue empty
// a stall on tok_out fills the queue, then text_in.ready drops
module utf8_text_pretokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  utp_in_if.sink    text_in,
  utp_out_if.source tok_out
);
  import utp_pkg::*;

  // front to queue
  logic push;
  cmd_t cmd;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_valid;
  cmd_t head;

  // front: utf-8 decode, normalize, classify, encode into a slot mask
  utp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .text_in (text_in),
    .q_full  (q_full),
    .push    (push),
    .cmd     (cmd)
  );

  // short queue decouples intake from result delivery
  utp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .valid    (q_valid)
  );

  // back: walk the slot mask, one result beat per cycle while tok_out is not stalled
  utp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .head   (head),
    .q_pop  (q_pop),
    .tok_out(tok_out)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command pushed into full queue");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // end of text is always the final beat of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (tok_out.valid && tok_out.kind == KIND_END) |-> tok_out.last_of_run)
    else $error("end beat without last_of_run");

  // boundary and end beats carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (tok_out.valid && tok_out.kind != KIND_BYTE) |-> tok_out.out_byte == 8'd0)
    else $error("marker beat with nonzero byte");

endmodule
